@@ design/bchd_pkg.sv @@
// Shared types and constants for the button click and hold detector.
package bchd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [1:0] ClicksForTriple = 2'd3;

  localparam logic [CfgW-1:0] DebounceRst  = 16'd20;
  localparam logic [CfgW-1:0] ClickMaxRst  = 16'd300;
  localparam logic [CfgW-1:0] HoldRst      = 16'd1000;
  localparam logic [CfgW-1:0] MultiGapRst  = 16'd300;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_CLICK_MAX = 2'd1,
    CFG_HOLD      = 2'd2,
    CFG_MULTI_GAP = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_PRESSED     = 3'd1,
    MODE_WAIT_SECOND = 3'd2,
    MODE_WAIT_THIRD  = 3'd3,
    MODE_HELD        = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CLICK   = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_TRIPLE  = 3'd3,
    EV_HOLD    = 3'd4,
    EV_RELEASE = 3'd5
  } event_e;

  // Thresholds used by the click state machine.
  typedef struct packed {
    logic [CfgW-1:0] click_max_time;
    logic [CfgW-1:0] hold_time;
    logic [CfgW-1:0] multi_click_gap;
  } fsm_cfg_t;

endpackage

@@ design/bchd_debounce.sv @@
// Debouncer: accepts a raw level change once the debounce time has passed.
module bchd_debounce
  import bchd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic             raw_i,
  input  logic [TimeW-1:0] now_i,
  input  logic [CfgW-1:0]  debounce_time_i,
  output logic             level_o
);

  logic             stable_q, stable_d;
  logic [TimeW-1:0] change_q, change_d;
  logic [TimeW-1:0] since_w;
  logic             take_w;

  always_comb begin
    since_w  = now_i - change_q;
    take_w   = (raw_i != stable_q) && (since_w >= {{(TimeW-CfgW){1'b0}}, debounce_time_i});
    stable_d = take_w ? raw_i : stable_q;
    change_d = take_w ? now_i : change_q;
    level_o  = stable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      change_q <= '0;
    end else if (fire_i) begin
      stable_q <= stable_d;
      change_q <= change_d;
    end
  end

endmodule

@@ design/bchd_fsm.sv @@
// Click / double / triple / hold / release state machine.
module bchd_fsm
  import bchd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic             level_i,
  input  logic [TimeW-1:0] now_i,
  input  fsm_cfg_t         cfg_i,
  output event_e           event_o,
  output logic [TimeW-1:0] held_time_o
);

  mode_e            mode_q, mode_d;
  logic [TimeW-1:0] press_q, press_d;
  logic [TimeW-1:0] release_q, release_d;
  logic             fired_q, fired_d;
  logic [1:0]       clicks_q, clicks_d;

  logic [TimeW-1:0] held_w;
  logic [TimeW-1:0] gap_w;
  logic [1:0]       clicks_inc;
  logic             press_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      press_q   <= '0;
      release_q <= '0;
      fired_q   <= 1'b0;
      clicks_q  <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      press_q   <= press_d;
      release_q <= release_d;
      fired_q   <= fired_d;
      clicks_q  <= clicks_d;
    end
  end

  always_comb begin
    held_w     = now_i - press_q;
    gap_w      = now_i - release_q;
    clicks_inc = clicks_q + 2'd1;
    mode_d     = mode_q;
    press_d    = press_q;
    release_d  = release_q;
    fired_d    = fired_q;
    clicks_d   = clicks_q;
    press_new  = 1'b0;
    event_o    = EV_NONE;

    case (mode_q)
      MODE_PRESSED: begin
        if (!level_i) begin
          release_d = now_i;
          if (held_w < {{(TimeW-CfgW){1'b0}}, cfg_i.click_max_time}) begin
            if (clicks_inc >= ClicksForTriple) begin
              event_o  = EV_TRIPLE;
              clicks_d = '0;
              mode_d   = MODE_IDLE;
            end else if (clicks_inc == 2'd2) begin
              clicks_d = clicks_inc;
              mode_d   = MODE_WAIT_THIRD;
            end else begin
              clicks_d = clicks_inc;
              mode_d   = MODE_WAIT_SECOND;
            end
          end else begin
            // long press released: release only reported after a hold
            clicks_d = '0;
            mode_d   = MODE_IDLE;
            if (fired_q) begin
              event_o = EV_RELEASE;
            end
          end
        end else if ((held_w >= {{(TimeW-CfgW){1'b0}}, cfg_i.hold_time}) && !fired_q) begin
          fired_d  = 1'b1;
          clicks_d = '0;
          mode_d   = MODE_HELD;
          event_o  = EV_HOLD;
        end
      end
      MODE_WAIT_SECOND, MODE_WAIT_THIRD: begin
        if (level_i) begin
          press_d   = now_i;
          press_new = 1'b1;
          fired_d   = 1'b0;
          mode_d    = MODE_PRESSED;
        end else if (gap_w >= {{(TimeW-CfgW){1'b0}}, cfg_i.multi_click_gap}) begin
          event_o  = (mode_q == MODE_WAIT_SECOND) ? EV_CLICK : EV_DOUBLE;
          clicks_d = '0;
          mode_d   = MODE_IDLE;
        end
      end
      MODE_HELD: begin
        if (!level_i) begin
          event_o  = EV_RELEASE;
          clicks_d = '0;
          mode_d   = MODE_IDLE;
        end
      end
      default: begin
        if (level_i) begin
          press_d   = now_i;
          press_new = 1'b1;
          fired_d   = 1'b0;
          clicks_d  = '0;
          mode_d    = MODE_PRESSED;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
    endcase

    // a fresh press stamp means zero time held
    if ((mode_d == MODE_PRESSED || mode_d == MODE_HELD) && !press_new) begin
      held_time_o = held_w;
    end else begin
      held_time_o = '0;
    end
  end

endmodule

@@ design/button_click_hold_detector.sv @@
// Top level of the button click and hold detector.
//
//  channel   | dir | handshake              | payload
//  s_axis    | in  | s_axis_tvalid/tready   | raw_pressed, now_time
//  m_axis    | out | m_axis_tvalid/tready   | event_code, debounced_pressed, held_time
//  cfg       | in  | cfg_we_i (no stall)    | cfg_idx_i, cfg_data_i
//
// One request per cycle sustained while m_axis is not stalled; after s_axis acceptance a
// poll is held in the input register, then the debounce and click logic feed its result
// into the m_axis result register, from which it can be taken.
// The state update for one poll is a single pass through that logic, so the
// poll-to-poll state loop closes before the next poll is handled.
// Reset clears the state machine, debouncer and both handshake stages, and
// loads the default thresholds. A stalled m_axis holds its result while the
// input register still takes one more request.
module button_click_hold_detector
  import bchd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,   // [0] raw_pressed, [32:1] now_time, rest zero
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [39:0]        m_axis_tdata,   // [2:0] event_code, [3] debounced_pressed,
                                             // [35:4] held_time, rest zero
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  // configuration registers
  logic [CfgW-1:0] debounce_q, click_max_q, hold_q, gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceRst;
      click_max_q <= ClickMaxRst;
      hold_q      <= HoldRst;
      gap_q       <= MultiGapRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:  debounce_q  <= cfg_data_i;
        CFG_CLICK_MAX: click_max_q <= cfg_data_i;
        CFG_HOLD:      hold_q      <= cfg_data_i;
        CFG_MULTI_GAP: gap_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic             in_vld_q;
  logic             raw_q;
  logic [TimeW-1:0] now_q;
  logic             out_vld_q;
  logic             fire;

  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      raw_q <= s_axis_tdata[0];
      now_q <= s_axis_tdata[32:1];
    end
  end

  // debounce and event logic
  logic             level;
  event_e           ev;
  logic [TimeW-1:0] held;
  fsm_cfg_t         fsm_cfg;

  assign fsm_cfg = '{click_max_time: click_max_q, hold_time: hold_q, multi_click_gap: gap_q};

  bchd_debounce u_debounce (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .raw_i           (raw_q),
    .now_i           (now_q),
    .debounce_time_i (debounce_q),
    .level_o         (level)
  );

  bchd_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .level_i     (level),
    .now_i       (now_q),
    .cfg_i       (fsm_cfg),
    .event_o     (ev),
    .held_time_o (held)
  );

  // result register
  event_e           ev_q;
  logic             level_q;
  logic [TimeW-1:0] held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      ev_q    <= ev;
      level_q <= level;
      held_q  <= held;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, held_q, level_q, ev_q};

  // a hold is only reported while the debounced level is pressed
  a_hold_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ev_q == EV_HOLD) |-> level_q)
    else $error("hold event with released level");

  // release and click series end with the button up and no held time
  a_release_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (ev_q == EV_RELEASE || ev_q == EV_CLICK || ev_q == EV_DOUBLE ||
      ev_q == EV_TRIPLE)) |-> (!level_q && held_q == '0))
    else $error("release or click event while pressed");

  // nonzero held time only in the pressed or held modes, where the level is up
  a_held_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && held_q != '0) |-> level_q)
    else $error("held time reported while released");

  // a stalled result register must not be overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !fire)
    else $error("result overwritten under stall");

endmodule

@@ verif/tb.sv @@
// Testbench for button_click_hold_detector: directed gestures, threshold extremes, random polls.
`timescale 1ns / 1ps

module tb;
  import bchd_pkg::*;

  localparam int unsigned StallLimit = 5000;  // cycles with no handshake on either side
  localparam int unsigned PollTarget = 1650;

  // One expected result per accepted poll.
  typedef struct packed {
    event_e      code;
    logic        level;
    logic [31:0] held;
  } poll_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata = '0;   // [0] raw_pressed, [32:1] now_time, rest zero
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;        // [2:0] event_code, [3] debounced_pressed,
                                          // [35:4] held_time, rest zero
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]   cfg_data_i = '0;

  button_click_hold_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Gesture model: own copy of thresholds, debouncer and click state machine.
  // ---------------------------------------------------------------------------
  logic [15:0] thr_debounce  = DebounceRst;
  logic [15:0] thr_click_max = ClickMaxRst;
  logic [15:0] thr_hold      = HoldRst;
  logic [15:0] thr_gap       = MultiGapRst;

  mode_e       gm_mode       = MODE_IDLE;
  logic [31:0] gm_press_at   = '0;
  logic [31:0] gm_release_at = '0;
  logic [31:0] gm_change_at  = '0;
  logic        gm_level      = 1'b0;
  logic        gm_hold_fired = 1'b0;
  logic [1:0]  gm_clicks     = '0;

  // Advances the model by one poll and returns what the block should report.
  function automatic poll_result_t classify_poll(input logic raw, input logic [31:0] now);
    poll_result_t r;
    logic [31:0]  since_change;
    logic [31:0]  held;
    logic [31:0]  since_release;
    r.code = EV_NONE;
    since_change = now - gm_change_at;
    // debouncer: a level change is taken once the debounce window has passed
    if (raw != gm_level && since_change >= 32'(thr_debounce)) begin
      gm_level     = raw;
      gm_change_at = now;
    end
    held          = now - gm_press_at;
    since_release = now - gm_release_at;
    case (gm_mode)
      MODE_PRESSED: begin
        if (!gm_level) begin
          gm_release_at = now;
          if (held < 32'(thr_click_max)) begin
            gm_clicks = gm_clicks + 2'd1;
            if (gm_clicks >= ClicksForTriple) begin
              // third short press reports at once, no gap wait
              r.code    = EV_TRIPLE;
              gm_clicks = '0;
              gm_mode   = MODE_IDLE;
            end else if (gm_clicks == 2'd2) begin
              gm_mode = MODE_WAIT_THIRD;
            end else begin
              gm_mode = MODE_WAIT_SECOND;
            end
          end else begin
            // long press ending before hold: release only if hold already fired
            gm_clicks = '0;
            gm_mode   = MODE_IDLE;
            if (gm_hold_fired) r.code = EV_RELEASE;
          end
        end else if (held >= 32'(thr_hold) && !gm_hold_fired) begin
          gm_hold_fired = 1'b1;
          gm_clicks     = '0;
          gm_mode       = MODE_HELD;
          r.code        = EV_HOLD;
        end
      end
      MODE_WAIT_SECOND, MODE_WAIT_THIRD: begin
        if (gm_level) begin
          gm_press_at   = now;
          gm_hold_fired = 1'b0;
          gm_mode       = MODE_PRESSED;
        end else if (since_release >= 32'(thr_gap)) begin
          r.code    = (gm_mode == MODE_WAIT_SECOND) ? EV_CLICK : EV_DOUBLE;
          gm_clicks = '0;
          gm_mode   = MODE_IDLE;
        end
      end
      MODE_HELD: begin
        if (!gm_level) begin
          r.code    = EV_RELEASE;
          gm_clicks = '0;
          gm_mode   = MODE_IDLE;
        end
      end
      default: begin
        if (gm_level) begin
          gm_press_at   = now;
          gm_hold_fired = 1'b0;
          gm_clicks     = '0;
          gm_mode       = MODE_PRESSED;
        end else begin
          gm_mode = MODE_IDLE;
        end
      end
    endcase
    r.level = gm_level;
    r.held  = (gm_mode == MODE_PRESSED || gm_mode == MODE_HELD) ? (now - gm_press_at) : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard, result counting and watchdog
  // ---------------------------------------------------------------------------
  poll_result_t poll_outcomes[$];
  int unsigned  mismatches  = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  events_seen[6];
  bit           idle_en = 1'b1;  // random gaps on both sides

  task automatic flag_mismatch(input string why, input poll_result_t want,
                               input poll_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t MISMATCH %s: exp ev=%0d lvl=%0b held=%0d, got ev=%0d lvl=%0b held=%0d",
               $realtime, why, want.code, want.level, want.held,
               got.code, got.level, got.held);
  endtask

  always @(posedge clk_i) begin : scoreboard
    poll_result_t want;
    poll_result_t got;
    bit           moved;
    moved = 1'b0;
    // expectation first, so even a result handed back with its own poll would find it
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      poll_outcomes.push_back(classify_poll(s_axis_tdata[0], s_axis_tdata[32:1]));
      moved = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      moved      = 1'b1;
      got.code   = event_e'(m_axis_tdata[2:0]);
      got.level  = m_axis_tdata[3];
      got.held   = m_axis_tdata[35:4];
      if (poll_outcomes.size() == 0) begin
        flag_mismatch("result with no poll pending", '0, got);
      end else begin
        want = poll_outcomes.pop_front();
        if (got.code != want.code || got.level != want.level || got.held != want.held)
          flag_mismatch("field", want, got);
        else if (int'(got.code) < 6)
          events_seen[int'(got.code)]++;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles", StallLimit);
      $display("button_click_hold_detector verification failed");
      $finish;
    end
  end

  // Receiver: drops ready at random, with a chance of 12 in a hundred, while idling is on.
  always @(posedge clk_i) begin
    m_axis_tready <= idle_en ? ($urandom_range(99) >= 12) : 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  int unsigned polls_sent  = 0;
  int unsigned phases_run  = 0;
  logic [31:0] clock_ms    = '0;  // time stamp carried in the polls

  // Sends one poll; entered and left at a rising edge, returns on acceptance.
  task automatic send_poll(input logic raw, input logic [31:0] now);
    if (idle_en && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, now, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    polls_sent++;
  endtask

  // Stops the request stream and waits until every result is back.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);  // the last accepted poll is queued by now
    while (poll_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);  // margin for the input and result registers
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_DEBOUNCE:  thr_debounce  = val;
      CFG_CLICK_MAX: thr_click_max = val;
      CFG_HOLD:      thr_hold      = val;
      default:       thr_gap       = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [15:0] deb, input logic [15:0] clk_max,
                                input logic [15:0] hld, input logic [15:0] gap);
    wait_quiet();
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_CLICK_MAX, clk_max);
    write_reg(CFG_HOLD, hld);
    write_reg(CFG_MULTI_GAP, gap);
    phases_run++;
  endtask

  // Polls at a given level for a span of ms, with bounce and rare time jumps.
  // At least one poll goes out, even for a zero span.
  task automatic hold_level(input logic level, input int unsigned span,
                            input int unsigned step_max);
    int unsigned elapsed;
    logic        raw;
    elapsed = 0;
    do begin
      elapsed  += $urandom_range(1, step_max);
      clock_ms += $urandom_range(1, step_max);
      raw = level;
      if ($urandom_range(99) < 10) raw = ~level;          // contact bounce
      if ($urandom_range(199) == 0) clock_ms = $urandom(); // time stamp jump
      send_poll(raw, clock_ms);
    end while (elapsed < span);
  endtask

  // One gesture: a short series of presses of mixed length, then a rest.
  task automatic play_gesture(input int unsigned step_max);
    int unsigned presses;
    int unsigned dur;
    presses = $urandom_range(1, 4);
    repeat (presses) begin
      case ($urandom_range(2))
        0:       dur = thr_debounce + $urandom_range(0, thr_click_max);
        1:       dur = thr_click_max + $urandom_range(0, thr_hold);
        default: dur = thr_hold + thr_debounce + $urandom_range(0, thr_hold / 2 + step_max);
      endcase
      hold_level(1'b1, dur + thr_debounce, step_max);
      hold_level(1'b0, thr_debounce + $urandom_range(0, thr_gap + thr_gap / 2), step_max);
    end
    hold_level(1'b0, thr_debounce + thr_gap + $urandom_range(0, thr_gap), step_max);
  endtask

  function automatic logic [15:0] pick_threshold(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic int unsigned step_for_thresholds();
    int unsigned top;
    top = thr_debounce;
    if (thr_click_max > top) top = thr_click_max;
    if (thr_hold > top) top = thr_hold;
    if (thr_gap > top) top = thr_gap;
    return top / 16 + 1;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds (20 / 300 / 1000 / 300): each gesture kind once.
  task automatic test_default_gestures();
    send_poll(1'b0, 32'd0);        // time zero, nothing happens
    send_poll(1'b1, 32'd10);       // inside debounce window: filtered
    send_poll(1'b1, 32'd100);      // press accepted
    send_poll(1'b1, 32'd150);
    send_poll(1'b0, 32'd200);      // short press, wait for second
    send_poll(1'b0, 32'd600);      // gap over: single click
    send_poll(1'b1, 32'd700);
    send_poll(1'b0, 32'd800);
    send_poll(1'b1, 32'd900);
    send_poll(1'b0, 32'd1000);     // second short press
    send_poll(1'b0, 32'd1400);     // double
    send_poll(1'b1, 32'd1500);
    send_poll(1'b0, 32'd1600);
    send_poll(1'b1, 32'd1700);
    send_poll(1'b0, 32'd1800);
    send_poll(1'b1, 32'd1900);
    send_poll(1'b0, 32'd2000);     // third short press fires triple at once
    send_poll(1'b1, 32'd2100);
    send_poll(1'b1, 32'd3100);     // hold
    send_poll(1'b1, 32'd3500);
    send_poll(1'b0, 32'd3600);     // release after hold
    send_poll(1'b1, 32'd3700);
    send_poll(1'b0, 32'd4200);     // long press without hold: silent return to idle
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'h0000_0010); // press spans the time stamp wrap
    send_poll(1'b0, 32'h0000_0200);
  endtask

  // All thresholds at zero, then all at full scale.
  task automatic test_threshold_extremes();
    set_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
    clock_ms = $urandom();
    repeat (3) play_gesture(4);
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (2) play_gesture(4096);
  endtask

  // Random thresholds per phase, gestures with bounce; every fourth phase without idling.
  task automatic test_random_gestures();
    int unsigned phase_end;
    while (polls_sent < PollTarget) begin
      set_thresholds(pick_threshold(0, 40), pick_threshold(30, 400),
                     pick_threshold(60, 900), pick_threshold(30, 400));
      idle_en   = (phases_run % 4) != 3;
      clock_ms  = $urandom();
      phase_end = polls_sent + 200;
      while (polls_sent < phase_end && polls_sent < PollTarget)
        play_gesture(step_for_thresholds());
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_gestures();
    test_threshold_extremes();
    test_random_gestures();
    wait_quiet();

    $display("Ran %0d polls over %0d threshold settings; %0d mismatches.",
             polls_sent, phases_run, mismatches);
    $display("Events matched: click %0d double %0d triple %0d hold %0d release %0d",
             events_seen[EV_CLICK], events_seen[EV_DOUBLE], events_seen[EV_TRIPLE],
             events_seen[EV_HOLD], events_seen[EV_RELEASE]);
    if (mismatches == 0 && poll_outcomes.size() == 0) begin
      $display("button_click_hold_detector verification clean");
    end else begin
      $display("button_click_hold_detector verification failed");
    end
    $finish;
  end

endmodule
